/* design/arss_pkg.sv */
package arss_pkg;

  localparam int SAMPLE_W = 10;
  localparam int STORED_W = 16;
  localparam int OUT_W    = 10;

  typedef enum logic [1:0] {
    ACT_MEASURE   = 2'd0,
    ACT_CALIBRATE = 2'd1,
    ACT_RESET     = 2'd2,
    ACT_LOAD      = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SAMPLE_W-1:0] sample;
    logic [STORED_W-1:0] stored_low;
    logic [STORED_W-1:0] stored_high;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] scaled;
    logic [OUT_W-1:0] raw_echo;
    logic [OUT_W-1:0] bound_low;
    logic [OUT_W-1:0] bound_high;
  } result_t;

endpackage

/* design/arss_divider.sv */
// Restoring divider, one quotient bit per cycle.
module arss_divider #(
  parameter int NW = 16,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          fits;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* design/arss_multiplier.sv */
// Shift-add multiplier, multiplier bits taken MSB first, one per cycle.
// The caller guarantees the product fits PW bits.
module arss_multiplier #(
  parameter int AW = 10,
  parameter int PW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [PW-1:0] b,
  output logic          done,
  output logic [PW-1:0] product
);

  localparam int CW = (AW > 1) ? $clog2(AW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] a_sh;
  logic [PW-1:0] b_r;
  logic [PW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= a;
        b_r  <= b;
        acc  <= '0;
      end else if (busy) begin
        acc  <= {acc[PW-2:0], 1'b0} + (a_sh[AW-1] ? b_r : '0);
        a_sh <= {a_sh[AW-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(AW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

/* design/auto_range_sensor_scaler.sv */
// Channel  Signals                             Direction  Payload
// item     item_valid, item_stall, item        in         arss_pkg::item_t
// result   result_valid, result_stall, result  out        arss_pkg::result_t
//
// One request at a time; item_stall is high from acceptance until the result
// has moved into the output register. Calibrate, reset, load and a measure
// with empty bounds go straight to the finish state; any other measure runs the
// bit-serial divider (B+FRACTION_BITS steps) and then the multiplier (W steps),
// B = clog2(SAMPLE_MAX+1), W = max(B, 10).
// rst (synchronous) sets the bounds to SAMPLE_MAX / 0 and empties the output.
// A stalled result waits in its register while the next request is worked
// on; that result moves in at the edge the waiting one leaves.
module auto_range_sensor_scaler #(
  parameter int SAMPLE_MAX    = 1023,
  parameter int FRACTION_BITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  arss_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output arss_pkg::result_t result
);

  // Bits to hold SAMPLE_MAX; bounds must also hold any raw sample.
  localparam int SB  = $clog2(SAMPLE_MAX + 1);
  localparam int BDW = (SB > arss_pkg::SAMPLE_W) ? SB : arss_pkg::SAMPLE_W;
  // Dividend SAMPLE_MAX << FRACTION_BITS; quotient and product fit NW bits.
  localparam int NW  = SB + FRACTION_BITS;
  localparam int SW  = (NW > arss_pkg::OUT_W) ? NW : arss_pkg::OUT_W;

  localparam logic [NW-1:0]  DIVIDEND = NW'(SAMPLE_MAX) << FRACTION_BITS;
  localparam logic [BDW-1:0] SMAX_B   = BDW'(SAMPLE_MAX);

  typedef enum logic [1:0] {IDLE, DIVIDE, MULTIPLY, FINISH} state_t;

  state_t                          state;
  logic [BDW-1:0]                  low_bound;
  logic [BDW-1:0]                  high_bound;
  logic [BDW-1:0]                  v_off;
  logic [BDW-1:0]                  divisor;
  logic [arss_pkg::SAMPLE_W-1:0]   raw;
  arss_pkg::action_t               act;
  logic [arss_pkg::OUT_W-1:0]      scaled;
  logic                            div_start;
  logic                            mul_start;

  logic                            div_done;
  logic [NW-1:0]                   quotient;
  logic                            mul_done;
  logic [NW-1:0]                   product;

  logic                            accept;
  logic                            result_load;
  logic [BDW-1:0]                  s_w;
  logic                            empty;
  logic [BDW-1:0]                  v_clamp;
  logic [BDW-1:0]                  v_off_next;
  logic [BDW-1:0]                  range_w;
  logic [BDW-1:0]                  divisor_next;
  logic [BDW-1:0]                  low_next;
  logic [BDW-1:0]                  high_next;
  logic [BDW-1:0]                  restart_low;
  logic                            load_bad;
  logic [SW-1:0]                   prod_shift;

  assign item_stall  = (state != IDLE);
  assign accept      = item_valid && (state == IDLE);
  assign result_load = (state == FINISH) && (!result_valid || !result_stall);

  // Bound update and measure preparation, all from the current bounds.
  always_comb begin
    s_w          = BDW'(item.sample);
    empty        = low_bound > high_bound;
    v_clamp      = (s_w < low_bound) ? low_bound :
                   ((s_w > high_bound) ? high_bound : s_w);
    v_off_next   = v_clamp - low_bound;
    range_w      = high_bound - low_bound;
    divisor_next = (range_w == '0) ? BDW'(1) : range_w;
    restart_low  = (s_w < SMAX_B) ? s_w : SMAX_B;
    load_bad     = (item.stored_high > arss_pkg::STORED_W'(SAMPLE_MAX)) ||
                   (item.stored_low > item.stored_high);
    low_next     = low_bound;
    high_next    = high_bound;
    unique case (item.action)
      arss_pkg::ACT_MEASURE: begin
      end
      arss_pkg::ACT_CALIBRATE: begin
        low_next  = (s_w < low_bound) ? s_w : low_bound;
        high_next = (s_w > high_bound) ? s_w : high_bound;
      end
      arss_pkg::ACT_RESET: begin
        low_next  = restart_low;
        high_next = s_w;
      end
      arss_pkg::ACT_LOAD: begin
        if (load_bad) begin
          low_next  = restart_low;
          high_next = s_w;
        end else begin
          // Both are at most SAMPLE_MAX here, so nothing is lost.
          low_next  = BDW'(item.stored_low);
          high_next = BDW'(item.stored_high);
        end
      end
      default: begin
      end
    endcase
  end

  // Drop the fraction, keep the field width.
  assign prod_shift = SW'(product) >> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      low_bound    <= SMAX_B;
      high_bound   <= '0;
      div_start    <= 1'b0;
      mul_start    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            raw        <= item.sample;
            act        <= item.action;
            low_bound  <= low_next;
            high_bound <= high_next;
            v_off      <= v_off_next;
            divisor    <= divisor_next;
            if (item.action == arss_pkg::ACT_MEASURE && !empty) begin
              div_start <= 1'b1;
              state     <= DIVIDE;
            end else begin
              scaled <= '0;
              state  <= FINISH;
            end
          end
        end
        DIVIDE: begin
          if (div_done) begin
            mul_start <= 1'b1;
            state     <= MULTIPLY;
          end
        end
        MULTIPLY: begin
          if (mul_done) begin
            scaled <= prod_shift[arss_pkg::OUT_W-1:0];
            state  <= FINISH;
          end
        end
        FINISH: begin
          if (result_load) begin
            result.scaled     <= scaled;
            result.raw_echo   <= raw;
            result.bound_low  <= low_bound[arss_pkg::OUT_W-1:0];
            result.bound_high <= high_bound[arss_pkg::OUT_W-1:0];
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  arss_divider #(
    .NW (NW),
    .DW (BDW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIVIDEND),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  arss_multiplier #(
    .AW (BDW),
    .PW (NW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (v_off),
    .b       (quotient),
    .done    (mul_done),
    .product (product)
  );

  // Bounds only move when a request is taken.
  a_bounds_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(low_bound) && $stable(high_bound)))
    else $error("bounds changed without a request");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == DIVIDE))
    else $error("divider finished outside the divide phase");

  // Only a measure can give a nonzero scaled value.
  a_scaled_zero: assert property (@(posedge clk) disable iff (rst)
    (result_load && act != arss_pkg::ACT_MEASURE) |=> (result.scaled == '0))
    else $error("nonzero scaled value for a non-measure request");

endmodule
